FILE: rtl/nsc_pkg.sv
package nsc_pkg;

  // Line limits
  localparam int MAX_LINE = 128;
  localparam int POS_W    = $clog2(MAX_LINE);
  localparam int LEN_W    = POS_W + 1;
  localparam int BYTE_W   = 8;
  localparam int TAG_LEN  = 6;

  // Character codes
  localparam logic [BYTE_W-1:0] NEWLINE    = 8'h0A;
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'd57;
  localparam logic [BYTE_W-1:0] ASCII_A    = 8'd65;
  localparam logic [BYTE_W-1:0] ASCII_F    = 8'd70;
  localparam logic [BYTE_W-1:0] HEX_RADIX  = 8'd16;
  localparam logic [BYTE_W-1:0] ALPHA_BIAS = ASCII_A - 8'd10;

  typedef logic [BYTE_W-1:0] byte_t;

  // One registered input request
  typedef struct packed {
    logic  valid;
    byte_t data;
  } stage_t;

  // One result request
  typedef struct packed {
    logic  sentence_ok;
    logic  tag_match;
    byte_t computed_sum;
    byte_t received_sum;
    byte_t line_length;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Expected "$GPRMC" character at a tag position
  function automatic byte_t tag_char(input logic [2:0] idx);
    byte_t c;
    unique case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Hex digit decode, 0-9 and A-F only
  function automatic hex_t hex_decode(input byte_t c);
    hex_t h;
    byte_t v;
    v = '0;
    h.ok = 1'b1;
    if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
      v = c - ASCII_ZERO;
    end else if (c >= ASCII_A && c <= ASCII_F) begin
      v = c - ALPHA_BIAS;
    end else begin
      h.ok = 1'b0;
    end
    h.val = v[3:0];
    return h;
  endfunction

endpackage

FILE: rtl/nmea_sentence_checksum_check_top.sv
// NMEA $GPRMC sentence checksum checker.
//
// Input channel: one received serial byte per request on in_rx_byte,
// accepted when in_valid is high and in_stall is low. One byte can be
// accepted every cycle while in_stall is low.
// Output channel: one result request per newline byte, none for other
// bytes. Fields: sentence_ok, tag_match, computed_sum, received_sum and
// line_length, taken when out_valid is high and out_stall is low.
// Flow: an accepted newline goes into the input register, then its result
// into the result register, which raises out_valid. The byte pipeline is
// an input register and a result register with the line state updated
// between them, one byte per cycle while in_stall is low.
// Reset (rst_n low, synchronous): both registers empty, line position,
// running XOR and recent bytes cleared, tag match flag set.
// Stall: a waiting result holds its fields; non-newline bytes keep
// flowing. A newline behind a stalled result waits in the input register,
// and in_stall rises until the result register is free again.
// Lines reaching 128 bytes without a newline restart silently.
module nmea_sentence_checksum_check_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  nsc_pkg::byte_t in_rx_byte,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_sentence_ok,
  output logic           out_tag_match,
  output nsc_pkg::byte_t out_computed_sum,
  output nsc_pkg::byte_t out_received_sum,
  output nsc_pkg::byte_t out_line_length
);
  import nsc_pkg::*;

  stage_t  stage;
  result_t result;
  result_t out_data;
  logic    is_newline;
  logic    out_free;
  logic    advance;
  logic    in_load;

  // Pipeline flow control
  assign out_free = !out_valid || !out_stall;
  assign advance  = stage.valid && (!is_newline || out_free);
  assign in_stall = stage.valid && !advance;
  assign in_load  = in_valid && !in_stall;

  nsc_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_load),
    .advance (advance),
    .rx_byte (in_rx_byte),
    .stage   (stage)
  );

  nsc_line_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .rx_byte    (stage.data),
    .is_newline (is_newline),
    .result     (result)
  );

  nsc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && is_newline),
    .out_stall (out_stall),
    .result    (result),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_sentence_ok  = out_data.sentence_ok;
  assign out_tag_match    = out_data.tag_match;
  assign out_computed_sum = out_data.computed_sum;
  assign out_received_sum = out_data.received_sum;
  assign out_line_length  = out_data.line_length;

endmodule

FILE: rtl/nsc_in_stage.sv
module nsc_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic           advance,
  input  nsc_pkg::byte_t rx_byte,
  output nsc_pkg::stage_t stage
);
  import nsc_pkg::*;

  logic  valid_r, valid_nxt;
  byte_t data_r, data_nxt;

  // Occupancy of the input register
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = rx_byte;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

FILE: rtl/nsc_line_check.sv
module nsc_line_check (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  nsc_pkg::byte_t   rx_byte,
  output logic             is_newline,
  output nsc_pkg::result_t result
);
  import nsc_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             prefix_ok_r, prefix_ok_nxt;
  byte_t            xor_r, xor_nxt;
  byte_t            recent_r [4];
  byte_t            recent_nxt [4];

  logic             mismatch;
  logic             prefix_now;
  logic [LEN_W-1:0] len;
  hex_t             hi, lo;
  byte_t            comp, recv;

  // Tag compare and result for the current byte
  always_comb begin
    is_newline = (rx_byte == NEWLINE);
    mismatch   = (pos_r < POS_W'(TAG_LEN)) && (rx_byte != tag_char(pos_r[2:0]));
    prefix_now = prefix_ok_r & ~mismatch;
    len        = LEN_W'(pos_r) + LEN_W'(1);
    hi         = hex_decode(recent_r[2]);
    lo         = hex_decode(recent_r[1]);
    recv       = BYTE_W'({hi.val, 4'b0} | (BYTE_W'(lo.val) & (HEX_RADIX - 8'd1)));
    if (len >= LEN_W'(TAG_LEN)) begin
      comp = xor_r ^ recent_r[0] ^ recent_r[1] ^ recent_r[2] ^ recent_r[3];
    end else begin
      comp = '0;
    end
    result.tag_match    = prefix_now;
    result.sentence_ok  = prefix_now & hi.ok & lo.ok & (comp == recv);
    result.computed_sum = comp;
    result.received_sum = recv;
    result.line_length  = BYTE_W'(len);
  end

  // Line state update; newline or overlong line starts over
  always_comb begin
    pos_nxt       = pos_r;
    prefix_ok_nxt = prefix_ok_r;
    xor_nxt       = xor_r;
    recent_nxt    = recent_r;
    if (step) begin
      if (is_newline || len >= LEN_W'(MAX_LINE)) begin
        pos_nxt       = '0;
        prefix_ok_nxt = 1'b1;
        xor_nxt       = '0;
        for (int i = 0; i < 4; i++) recent_nxt[i] = '0;
      end else begin
        pos_nxt       = POS_W'(len);
        prefix_ok_nxt = prefix_now;
        xor_nxt       = (pos_r != '0) ? (xor_r ^ rx_byte) : xor_r;
        recent_nxt[3] = recent_r[2];
        recent_nxt[2] = recent_r[1];
        recent_nxt[1] = recent_r[0];
        recent_nxt[0] = rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      prefix_ok_r <= 1'b1;
      xor_r       <= '0;
      for (int i = 0; i < 4; i++) recent_r[i] <= '0;
    end else begin
      pos_r       <= pos_nxt;
      prefix_ok_r <= prefix_ok_nxt;
      xor_r       <= xor_nxt;
      recent_r    <= recent_nxt;
    end
  end

endmodule

FILE: rtl/nsc_out_stage.sv
module nsc_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             out_stall,
  input  nsc_pkg::result_t result,
  output logic             out_valid,
  output nsc_pkg::result_t out_data
);
  import nsc_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  // Result register, holds while stalled
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = result;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: rtl/nsc_checker.sv
module nsc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input logic           out_sentence_ok,
  input logic           out_tag_match,
  input nsc_pkg::byte_t out_computed_sum,
  input nsc_pkg::byte_t out_received_sum
);
  import nsc_pkg::*;

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An accepted sentence must carry the tag
  a_ok_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sentence_ok |-> out_tag_match)
    else $error("sentence_ok without tag match");

  // An accepted sentence must have matching sums
  a_ok_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sentence_ok |-> out_computed_sum == out_received_sum)
    else $error("sentence_ok with differing checksums");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_computed_sum)
      && $stable(out_received_sum) && $stable(out_sentence_ok))
    else $error("stalled result changed");

endmodule

bind nmea_sentence_checksum_check_top nsc_checker u_nsc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sentence_ok  (out_sentence_ok),
  .out_tag_match    (out_tag_match),
  .out_computed_sum (out_computed_sum),
  .out_received_sum (out_received_sum)
);
